// ----- src/set_assoc_writeback_cache_lru_macros.svh -----
// Assertion macros used by the cache top level.
`ifndef SET_ASSOC_WRITEBACK_CACHE_LRU_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_LRU_MACROS_SVH

// Check that a condition implies another at the same edge.
`define SACL_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another at the next edge.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/sacl_pkg.sv -----
// Shared types, codes and helpers for the set-associative cache.
package sacl_pkg;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned OFF_W      = 3;
  localparam int unsigned SETF_W     = 8;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STORE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_STORE,
    OP_FILL,
    OP_NONE,
    OP_ERR
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] tag;
    logic [SETF_W-1:0] set;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } req_t;

  function automatic logic [DATA_W-1:0] byte_mask(logic [OFF_W-1:0] off,
                                                  logic [LEN_W-1:0] len);
    logic [15:0]       be;
    logic [DATA_W-1:0] m;
    be = (16'(1) << len) - 16'(1);
    be = be << off;
    for (int b = 0; b < 8; b++) begin
      m[b*8 +: 8] = {8{be[b]}};
    end
    return m;
  endfunction
endpackage

// ----- src/sacl_in_if.sv -----
// Request channel interface.
interface sacl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] address;
  logic [3:0]  access_length;
  logic [63:0] data_in;

  modport source(output valid, mode, address, access_length, data_in, input ready);
  modport sink(input valid, mode, address, access_length, data_in, output ready);
endinterface

// ----- src/sacl_out_if.sv -----
// Result channel interface.
interface sacl_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [63:0] read_data;
  logic        access_error;
  logic        writeback_valid;
  logic [31:0] writeback_address;
  logic [63:0] writeback_data;
  logic [31:0] hit_total;
  logic [31:0] request_total;

  modport source(output valid, hit, read_data, access_error, writeback_valid,
                 writeback_address, writeback_data, hit_total, request_total,
                 input ready);
  modport sink(input valid, hit, read_data, access_error, writeback_valid,
               writeback_address, writeback_data, hit_total, request_total,
               output ready);
endinterface

// ----- src/sacl_front.sv -----
// Front end: decode and classify requests, queue them for the back end.
module sacl_front import sacl_pkg::*; #(
  parameter int unsigned NUM_SETS   = 16,
  parameter int unsigned LINE_BYTES = 8,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sacl_in_if.sink      in_i,
  output logic         req_valid_o,
  output req_t         req_o,
  input  logic         req_pop_i
);
  localparam int unsigned OB     = $clog2(LINE_BYTES);
  localparam int unsigned SB     = $clog2(NUM_SETS);
  localparam int unsigned AW     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] AMASK = ADDR_W'((64'(1) << AW) - 64'(1));
  localparam logic [ADDR_W-1:0] OMASK = ADDR_W'((64'(1) << OB) - 64'(1));
  localparam logic [ADDR_W-1:0] SMASK = ADDR_W'((64'(1) << SB) - 64'(1));
  localparam int unsigned PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_FW = $clog2(FIFO_DEPTH + 1);

  logic [ADDR_W-1:0] addr_m, off_raw, set_raw, set_mod;
  logic              err;
  req_t              req_new;
  logic              push;

  req_t              fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_FW-1:0] cnt_q;

  always_comb begin
    addr_m  = in_i.address & AMASK;
    off_raw = addr_m & OMASK;
    set_raw = (addr_m >> OB) & SMASK;
    set_mod = (set_raw >= ADDR_W'(NUM_SETS)) ? set_raw - ADDR_W'(NUM_SETS) : set_raw;
    err     = (5'(off_raw[OFF_W-1:0]) + 5'(in_i.access_length)) > 5'(LINE_BYTES);
    req_new.tag  = addr_m >> (OB + SB);
    req_new.set  = set_mod[SETF_W-1:0];
    req_new.off  = off_raw[OFF_W-1:0];
    req_new.len  = in_i.access_length;
    req_new.data = in_i.data_in;
    case (in_i.mode)
      MODE_LOAD:  req_new.op = err ? OP_ERR : OP_LOAD;
      MODE_STORE: req_new.op = err ? OP_ERR : OP_STORE;
      MODE_FILL:  req_new.op = OP_FILL;
      default:    req_new.op = OP_NONE;
    endcase
  end

  assign in_i.ready  = (cnt_q != CNT_FW'(FIFO_DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign req_valid_o = (cnt_q != '0);
  assign req_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= req_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (req_pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_FW'(push) - CNT_FW'(req_pop_i);
    end
  end
endmodule

// ----- src/sacl_back.sv -----
// Back end: tag and line memories, ages, dirty bits, counters and result register.
module sacl_back import sacl_pkg::*; #(
  parameter int unsigned NUM_SETS   = 16,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned LINE_BYTES = 8,
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned AGE_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         req_valid_i,
  input  req_t         req_i,
  output logic         req_pop_o,
  sacl_out_if.source   out_o
);
  localparam int unsigned OB    = $clog2(LINE_BYTES);
  localparam int unsigned SB    = $clog2(NUM_SETS);
  localparam int unsigned AW    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int unsigned TAG_W = (AW > OB + SB) ? AW - OB - SB : 1;
  localparam int unsigned LINE_W = 8 * LINE_BYTES;
  localparam int unsigned NL    = NUM_SETS * NUM_WAYS;
  localparam int unsigned NL_W  = (NL > 1) ? $clog2(NL) : 1;
  localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam logic [DATA_W-1:0] LMASK = DATA_W'((65'(1) << LINE_W) - 65'(1));
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic [NUM_WAYS*TAG_W-1:0]  tag_mem  [NUM_SETS];
  logic [NUM_WAYS*LINE_W-1:0] data_mem [NUM_SETS];
  logic [NUM_WAYS*TAG_W-1:0]  rd_tag_q;
  logic [NUM_WAYS*LINE_W-1:0] rd_data_q;

  logic                state_q;
  req_t                cur_q;
  logic [AGE_BITS-1:0] age_q [NL];
  logic [AGE_BITS-1:0] age_d [NL];
  logic [NL-1:0]       dirty_q, dirty_d;
  logic [CNT_W-1:0]    hit_cnt_q, hit_cnt_d, req_cnt_q, req_cnt_d;

  logic                out_valid_q, hit_q, err_q, wbv_q;
  logic [DATA_W-1:0]   rdata_q, wbd_q;
  logic [ADDR_W-1:0]   wba_q;

  logic                start, fire, mem_we;
  logic [SET_W-1:0]    set_idx;
  logic [TAG_W-1:0]    tag_c;
  logic                hit_c, free_c, wbv_c;
  int unsigned         hit_way, vic_way;
  logic [AGE_BITS-1:0] best;
  logic [DATA_W-1:0]   bmask, line_c, rdata_c, wbd_c, vic_line;
  logic [ADDR_W-1:0]   wba_c;
  logic [NUM_WAYS*TAG_W-1:0]  tag_row_d;
  logic [NUM_WAYS*LINE_W-1:0] data_row_d;
  logic [AGE_BITS-1:0] way_age [NUM_WAYS];
  logic [NL_W-1:0]     way_idx [NUM_WAYS];

  assign start     = (state_q == ST_IDLE) && req_valid_i;
  assign req_pop_o = start;
  assign fire      = (state_q == ST_LOOK) && (!out_valid_q || out_o.ready);
  assign set_idx   = cur_q.set[SET_W-1:0];
  assign tag_c     = cur_q.tag[TAG_W-1:0];

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      way_idx[w] = NL_W'(int'(set_idx) * NUM_WAYS + w);
      way_age[w] = age_q[way_idx[w]];
    end
    hit_c   = 1'b0;
    hit_way = 0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit_c && way_age[w] != '0 && rd_tag_q[w*TAG_W +: TAG_W] == tag_c) begin
        hit_c   = 1'b1;
        hit_way = w;
      end
    end
    free_c  = 1'b0;
    vic_way = 0;
    best    = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!free_c) begin
        if (way_age[w] == '0) begin
          free_c  = 1'b1;
          vic_way = w;
        end else if (way_age[w] > best) begin
          best    = way_age[w];
          vic_way = w;
        end
      end
    end

    bmask    = byte_mask(cur_q.off, cur_q.len);
    line_c   = DATA_W'(rd_data_q[hit_way*LINE_W +: LINE_W]);
    vic_line = DATA_W'(rd_data_q[vic_way*LINE_W +: LINE_W]);
    wbv_c    = !free_c && dirty_q[way_idx[vic_way]];

    tag_row_d  = rd_tag_q;
    data_row_d = rd_data_q;
    for (int i = 0; i < NL; i++) begin
      age_d[i] = age_q[i];
    end
    dirty_d   = dirty_q;
    hit_cnt_d = hit_cnt_q;
    req_cnt_d = req_cnt_q;
    mem_we    = 1'b0;
    rdata_c   = '0;
    wbd_c     = '0;
    wba_c     = '0;

    case (cur_q.op)
      OP_LOAD, OP_STORE: begin
        req_cnt_d = (req_cnt_q == '1) ? req_cnt_q : req_cnt_q + 1'b1;
        for (int i = 0; i < NL; i++) begin
          if (age_q[i] != '0 && age_q[i] != AGE_MAX) begin
            age_d[i] = age_q[i] + 1'b1;
          end
        end
        if (hit_c) begin
          age_d[way_idx[hit_way]] = AGE_ONE;
          hit_cnt_d = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
          if (cur_q.op == OP_LOAD) begin
            rdata_c = (line_c & bmask) >> (8 * cur_q.off);
          end else begin
            data_row_d[hit_way*LINE_W +: LINE_W] = LINE_W'(((line_c & ~bmask) |
              ((cur_q.data << (8 * cur_q.off)) & bmask)) & LMASK);
            dirty_d[way_idx[hit_way]] = 1'b1;
            mem_we = 1'b1;
          end
        end
      end
      OP_FILL: begin
        if (wbv_c) begin
          wba_c = ADDR_W'((64'(rd_tag_q[vic_way*TAG_W +: TAG_W]) << (OB + SB)) |
                          (64'(set_idx) << OB));
          wbd_c = vic_line;
        end
        tag_row_d[vic_way*TAG_W +: TAG_W]    = tag_c;
        data_row_d[vic_way*LINE_W +: LINE_W] = LINE_W'(cur_q.data & LMASK);
        age_d[way_idx[vic_way]]   = AGE_ONE;
        dirty_d[way_idx[vic_way]] = 1'b0;
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fire && mem_we) begin
      tag_mem[set_idx]  <= tag_row_d;
      data_mem[set_idx] <= data_row_d;
    end
    if (start) begin
      rd_tag_q  <= tag_mem[req_i.set[SET_W-1:0]];
      rd_data_q <= data_mem[req_i.set[SET_W-1:0]];
      cur_q     <= req_i;
    end
    if (fire) begin
      hit_q   <= hit_c && (cur_q.op == OP_LOAD || cur_q.op == OP_STORE);
      err_q   <= (cur_q.op == OP_ERR);
      wbv_q   <= (cur_q.op == OP_FILL) && wbv_c;
      rdata_q <= rdata_c;
      wbd_q   <= wbd_c;
      wba_q   <= wba_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dirty_q     <= '0;
      hit_cnt_q   <= '0;
      req_cnt_q   <= '0;
      for (int i = 0; i < NL; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: if (start) state_q <= ST_LOOK;
        ST_LOOK: if (fire) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
      if (fire) begin
        out_valid_q <= 1'b1;
        dirty_q     <= dirty_d;
        hit_cnt_q   <= hit_cnt_d;
        req_cnt_q   <= req_cnt_d;
        for (int i = 0; i < NL; i++) begin
          age_q[i] <= age_d[i];
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.hit               = hit_q;
  assign out_o.read_data         = rdata_q;
  assign out_o.access_error      = err_q;
  assign out_o.writeback_valid   = wbv_q;
  assign out_o.writeback_address = wba_q;
  assign out_o.writeback_data    = wbd_q;
  assign out_o.hit_total         = hit_cnt_q;
  assign out_o.request_total     = req_cnt_q;
endmodule

// ----- src/set_assoc_writeback_cache_lru.sv -----
// Top level of the set-associative write-back cache with age-based replacement.
//
//   port    dir  contents
//   in_i    in   mode, address, access_length, data_in
//   out_o   out  hit, read_data, access_error, writeback_*, hit_total, request_total
//
// In the back end each transaction first reads the set's tag and line row from
// memory, then compares, updates ages and writes the row back when out_o has room.
// A two-entry queue between decode and the back end keeps accepting until full
// while a result waits on out_o. Reset clears ages, dirty bits and counters at once;
// tag and line memories are not cleared, a line with zero age is never read.
`include "set_assoc_writeback_cache_lru_macros.svh"
module set_assoc_writeback_cache_lru import sacl_pkg::*; #(
  parameter int unsigned NUM_SETS   = 16,
  parameter int unsigned NUM_WAYS   = 4,
  parameter int unsigned LINE_BYTES = 8,
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned AGE_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sacl_in_if.sink    in_i,
  sacl_out_if.source out_o
);
  logic req_valid, req_pop;
  req_t req;

  sacl_front #(
    .NUM_SETS  (NUM_SETS),
    .LINE_BYTES(LINE_BYTES),
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .req_valid_o(req_valid),
    .req_o      (req),
    .req_pop_i  (req_pop)
  );

  sacl_back #(
    .NUM_SETS  (NUM_SETS),
    .NUM_WAYS  (NUM_WAYS),
    .LINE_BYTES(LINE_BYTES),
    .ADDR_BITS (ADDR_BITS),
    .AGE_BITS  (AGE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_i      (req),
    .req_pop_o  (req_pop),
    .out_o      (out_o)
  );

  `SACL_ASSERT_IMPLIES(a_err_no_hit, out_o.valid && out_o.access_error, !out_o.hit && out_o.read_data == '0 && !out_o.writeback_valid, "error result carries data")
  `SACL_ASSERT_IMPLIES(a_hits_le_reqs, 1'b1, out_o.hit_total <= out_o.request_total, "hit count exceeds request count")
  `SACL_ASSERT_NEXT(a_pop_needs_item, req_pop, $past(req_valid), "queue popped while empty")
endmodule
